// ===== design/csiesc_pkg.sv =====
// Shared types and constants for the CSI escape sequence parser.
`timescale 1ns / 1ps
package csiesc_pkg;

    localparam int MAX_ARGS = 16;
    localparam int ARG_CNT_W = $clog2(MAX_ARGS + 1);
    localparam int ARG_IDX_W = 4;
    localparam int VAL_W = 32;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_PRIV_LO = 8'h3C;
    localparam logic [7:0] CH_PRIV_HI = 8'h3F;
    localparam logic [7:0] CH_INTER_LO = 8'h20;
    localparam logic [7:0] CH_INTER_HI = 8'h2F;
    localparam logic [VAL_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VALUE_EMPTY = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       begin_req;
    } item_t;

    typedef struct packed {
        logic                    arg_present;
        logic [ARG_IDX_W-1:0]    arg_index;
        logic signed [VAL_W-1:0] arg_value;
        logic                    is_final;
        logic [6:0]              final_byte;
        logic [5:0]              initial_byte;
        logic [5:0]              intermediate_byte;
        logic [ARG_CNT_W-1:0]    arg_count;
    } result_t;

endpackage

// ===== design/csiesc_ifs.sv =====
// Valid/ready channel interfaces for parser input bytes and parse results.
`timescale 1ns / 1ps
interface csiesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       begin_req;

    modport source (output valid, output byte_in, output begin_req, input ready);
    modport sink (input valid, input byte_in, input begin_req, output ready);
endinterface

interface csiesc_out_if;
    logic              valid;
    logic              ready;
    logic              arg_present;
    logic [3:0]        arg_index;
    logic signed [31:0] arg_value;
    logic              is_final;
    logic [6:0]        final_byte;
    logic [5:0]        initial_byte;
    logic [5:0]        intermediate_byte;
    logic [4:0]        arg_count;

    modport source (
        output valid, output arg_present, output arg_index, output arg_value,
        output is_final, output final_byte, output initial_byte,
        output intermediate_byte, output arg_count, input ready
    );
    modport sink (
        input valid, input arg_present, input arg_index, input arg_value,
        input is_final, input final_byte, input initial_byte,
        input intermediate_byte, input arg_count, output ready
    );
endinterface

// ===== design/csiesc_in_stage.sv =====
// Input register stage holding one received byte item.
`timescale 1ns / 1ps
module csiesc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  csiesc_pkg::item_t  in_item,
    input  logic               advance,
    output logic               item_valid,
    output csiesc_pkg::item_t  item
);
    import csiesc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;
endmodule

// ===== design/csiesc_parser.sv =====
// Parser state and per-byte result logic.
`timescale 1ns / 1ps
module csiesc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  csiesc_pkg::item_t   item,
    output logic                res_valid,
    output csiesc_pkg::result_t res
);
    import csiesc_pkg::*;

    logic                 active_reg, active_next;
    logic                 at_first_reg, at_first_next;
    logic                 only_digits_reg, only_digits_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic [ARG_CNT_W-1:0] closed_reg, closed_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic [5:0]           init_reg, init_next;
    logic [5:0]           inter_reg, inter_next;
    logic                 stopped_reg, stopped_next;

    logic                 bgn;
    logic [7:0]           c;
    logic                 act;
    logic                 first;
    logic                 od;
    logic                 ds;
    logic [ARG_CNT_W-1:0] closed;
    logic [ARG_CNT_W-1:0] closed_inc;
    logic [VAL_W-1:0]     acc;
    logic [5:0]           init_b;
    logic [5:0]           inter_b;
    logic                 stopped;
    logic                 is_digit;
    logic                 is_final;
    logic                 pend;
    logic [3:0]           digit;
    logic [VAL_W+3:0]     acc_x10;

    assign bgn = item.begin_req;
    assign c = item.byte_in;
    assign act = bgn || active_reg;
    assign first = bgn || at_first_reg;
    assign od = bgn || only_digits_reg;
    assign ds = !bgn && digit_seen_reg;
    assign closed = bgn ? '0 : closed_reg;
    assign closed_inc = closed + ARG_CNT_W'(1);
    assign acc = bgn ? '0 : acc_reg;
    assign init_b = bgn ? 6'd0 : init_reg;
    assign inter_b = bgn ? 6'd0 : inter_reg;
    assign stopped = !bgn && stopped_reg;
    assign is_digit = (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
    assign is_final = (c[7:6] == 2'b01) || ((c == CH_DOLLAR) && od);
    assign pend = ds && (closed < ARG_CNT_W'(MAX_ARGS));
    assign digit = c[3:0];
    assign acc_x10 = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{VAL_W{1'b0}}, digit};

    always_comb
    begin
        active_next = active_reg;
        at_first_next = at_first_reg;
        only_digits_next = only_digits_reg;
        digit_seen_next = digit_seen_reg;
        closed_next = closed_reg;
        acc_next = acc_reg;
        init_next = init_reg;
        inter_next = inter_reg;
        stopped_next = stopped_reg;
        res_valid = 1'b0;
        res = '0;
        if (act)
        begin
            active_next = 1'b1;
            at_first_next = 1'b0;
            only_digits_next = od;
            digit_seen_next = ds;
            closed_next = closed;
            acc_next = acc;
            init_next = init_b;
            inter_next = inter_b;
            stopped_next = stopped;
            res.initial_byte = init_b;
            res.intermediate_byte = inter_b;
            if (is_final)
            begin
                active_next = 1'b0;
                res_valid = 1'b1;
                res.arg_present = pend;
                res.arg_index = pend ? closed[ARG_IDX_W-1:0] : '0;
                res.arg_value = pend ? acc : '0;
                res.is_final = 1'b1;
                res.final_byte = c[6:0];
                res.arg_count = pend ? closed_inc : closed;
            end
            else
            begin
                only_digits_next = od && is_digit;
                if (!stopped)
                begin
                    if (first && (c >= CH_PRIV_LO) && (c <= CH_PRIV_HI))
                    begin
                        init_next = c[5:0];
                    end
                    else if (is_digit)
                    begin
                        digit_seen_next = 1'b1;
                        if (!ds)
                        begin
                            acc_next = {{(VAL_W-4){1'b0}}, digit};
                        end
                        else if (acc_x10 > {4'b0000, VALUE_MAX})
                        begin
                            acc_next = VALUE_MAX;
                        end
                        else
                        begin
                            acc_next = acc_x10[VAL_W-1:0];
                        end
                    end
                    else if (c == CH_SEMI)
                    begin
                        closed_next = closed_inc;
                        digit_seen_next = 1'b0;
                        acc_next = '0;
                        stopped_next = (closed_inc >= ARG_CNT_W'(MAX_ARGS));
                        res_valid = 1'b1;
                        res.arg_present = 1'b1;
                        res.arg_index = closed[ARG_IDX_W-1:0];
                        res.arg_value = ds ? acc : VALUE_EMPTY;
                    end
                    else if ((c >= CH_INTER_LO) && (c <= CH_INTER_HI))
                    begin
                        inter_next = c[5:0];
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            at_first_reg <= 1'b0;
            only_digits_reg <= 1'b1;
            digit_seen_reg <= 1'b0;
            closed_reg <= '0;
            acc_reg <= '0;
            init_reg <= '0;
            inter_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            active_reg <= active_next;
            at_first_reg <= at_first_next;
            only_digits_reg <= only_digits_next;
            digit_seen_reg <= digit_seen_next;
            closed_reg <= closed_next;
            acc_reg <= acc_next;
            init_reg <= init_next;
            inter_reg <= inter_next;
            stopped_reg <= stopped_next;
        end
    end
endmodule

// ===== design/csiesc_out_stage.sv =====
// Result register stage holding one parse result until taken.
`timescale 1ns / 1ps
module csiesc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_req,
    input  csiesc_pkg::result_t res_in,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output csiesc_pkg::result_t res_out
);
    import csiesc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance = !valid_reg || out_ready;
    assign valid_next = advance ? load_req : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_req)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out = res_reg;
endmodule

// ===== design/csi_escape_sequence_parser_core.sv =====
// Top level of the CSI escape sequence parser.
//
// Usage:
//   in_ch carries one byte item per handshake: byte_in and begin_req. Set
//   begin_req on the first byte after each CSI introducer; bytes that arrive
//   outside a sequence without begin_req are dropped with no result.
//   out_ch carries at most one result per byte: one per ';' that closes an
//   argument, and a closing result (is_final) on the final byte.
// Timing:
//   An item is registered in the input stage at acceptance; when the parser
//   takes it, its result is registered in the output stage and then shows on
//   out_ch. A new byte is taken every cycle while out_ch is not held off;
//   the rate is one item per cycle, since the single multiply-by-ten
//   accumulate on the argument is combinational.
// Stall:
//   While out_ch is held off with a result waiting, the input register
//   still accepts bytes until it is full, then in_ch.ready drops.
// Reset:
//   rst_n clears both stage valids and returns the parser to idle.
`timescale 1ns / 1ps
module csi_escape_sequence_parser_core (
    input logic         clk,
    input logic         rst_n,
    csiesc_in_if.sink   in_ch,
    csiesc_out_if.source out_ch
);
    import csiesc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    res_valid;
    result_t res;
    result_t res_out;

    assign in_item.byte_in = in_ch.byte_in;
    assign in_item.begin_req = in_ch.begin_req;

    csiesc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    csiesc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (item_valid && advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    csiesc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (item_valid && res_valid),
        .res_in    (res),
        .advance   (advance),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .res_out   (res_out)
    );

    assign out_ch.arg_present = res_out.arg_present;
    assign out_ch.arg_index = res_out.arg_index;
    assign out_ch.arg_value = res_out.arg_value;
    assign out_ch.is_final = res_out.is_final;
    assign out_ch.final_byte = res_out.final_byte;
    assign out_ch.initial_byte = res_out.initial_byte;
    assign out_ch.intermediate_byte = res_out.intermediate_byte;
    assign out_ch.arg_count = res_out.arg_count;
endmodule

// ===== verif/tb.sv =====
// Testbench for csi_escape_sequence_parser_core: directed and random byte streams.
`timescale 1ns / 1ps
module tb;
    import csiesc_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_FINAL_HI = 8'h7F;

    logic clk;
    logic rst_n;

    csiesc_in_if in_ch();
    csiesc_out_if out_ch();

    csi_escape_sequence_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // parser shadow state
    logic                 p_active;
    logic                 p_first;
    logic                 p_only_digits;
    logic                 p_digit_seen;
    logic [ARG_CNT_W-1:0] p_closed;
    logic [VAL_W-1:0]     p_acc;
    logic [5:0]           p_init;
    logic [5:0]           p_inter;
    logic                 p_stopped;

    result_t expected_results[$];
    int      n_errors;
    int      n_counted;
    int      cycles;
    int      stall_left;
    bit      idle_on;
    logic    seq_begin;

    function automatic void restart_parse();
        p_first = 1'b0;
        p_only_digits = 1'b1;
        p_digit_seen = 1'b0;
        p_closed = '0;
        p_acc = '0;
        p_init = '0;
        p_inter = '0;
        p_stopped = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, input logic beg,
                                      output result_t r);
        logic             first;
        logic             is_digit;
        logic             pend;
        logic [VAL_W-1:0] d;
        r = '0;
        is_digit = (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
        if (beg)
        begin
            restart_parse();
            p_active = 1'b1;
            p_first = 1'b1;
        end
        if (!p_active)
            return 1'b0;
        first = p_first;
        p_first = 1'b0;
        if (((c >= CH_FINAL_LO) && (c <= CH_FINAL_HI)) || (c == CH_DOLLAR && p_only_digits))
        begin
            pend = p_digit_seen && (p_closed < MAX_ARGS);
            r.arg_present = pend;
            r.arg_index = pend ? p_closed[ARG_IDX_W-1:0] : '0;
            r.arg_value = pend ? p_acc : '0;
            r.is_final = 1'b1;
            r.final_byte = c[6:0];
            r.initial_byte = p_init;
            r.intermediate_byte = p_inter;
            r.arg_count = p_closed + ARG_CNT_W'(pend);
            p_active = 1'b0;
            return 1'b1;
        end
        if (!is_digit)
            p_only_digits = 1'b0;
        if (p_stopped)
            return 1'b0;
        if (first && (c >= CH_PRIV_LO) && (c <= CH_PRIV_HI))
        begin
            p_init = c[5:0];
        end
        else if (is_digit)
        begin
            d = VAL_W'(c - CH_DIGIT_LO);
            if (!p_digit_seen)
            begin
                p_acc = d;
                p_digit_seen = 1'b1;
            end
            else if (p_acc > (VALUE_MAX - d) / 10)
                p_acc = VALUE_MAX;
            else
                p_acc = p_acc * 10 + d;
        end
        else if (c == CH_SEMI)
        begin
            r.arg_present = 1'b1;
            r.arg_index = p_closed[ARG_IDX_W-1:0];
            r.arg_value = p_digit_seen ? p_acc : VALUE_EMPTY;
            r.initial_byte = p_init;
            r.intermediate_byte = p_inter;
            p_closed = p_closed + ARG_CNT_W'(1);
            p_digit_seen = 1'b0;
            p_acc = '0;
            if (p_closed >= MAX_ARGS)
                p_stopped = 1'b1;
            return 1'b1;
        end
        else if ((c >= CH_INTER_LO) && (c <= CH_INTER_HI))
        begin
            p_inter = c[5:0];
            p_stopped = 1'b1;
        end
        return 1'b0;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic beg);
        result_t r;
        while (idle_on && $urandom_range(0, 99) < 27)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.byte_in = b;
        in_ch.begin_req = beg;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (beg || p_active)
            n_counted++;
        if (parse_byte(b, beg, r))
            expected_results.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_seq_byte(input logic [7:0] b);
        send_byte(b, seq_begin);
        seq_begin = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == 0);
    endtask

    task automatic test_basic();
        send_byte("A", 1'b0);
        send_byte("?", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte("1", 1'b0);
        send_byte("2", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(";", 1'b0);
        send_byte(";", 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("3", 1'b0);
        send_byte("<", 1'b0);
        send_byte("h", 1'b0);
    endtask

    task automatic test_dollar_and_intermediate();
        send_text("$");
        send_text("5$");
        send_text(" $7q");
        send_text("12");
        send_text("3;@");
    endtask

    task automatic test_saturation_and_limit();
        send_byte("9", 1'b1);
        repeat (10) send_byte("9", 1'b0);
        repeat (17) send_byte(";", 1'b0);
        send_byte("5", 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        stall_left = 120;
        repeat (5) send_text(";;;;;;;;A");
        idle_on = 1'b1;
    endtask

    task automatic send_sequence();
        int n_args;
        int n_dig;
        int sel;
        seq_begin = 1'b1;
        if ($urandom_range(0, 99) < 20)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 10);
            return;
        end
        if ($urandom_range(0, 99) < 30)
            send_seq_byte(8'(CH_PRIV_LO + $urandom_range(0, 3)));
        n_args = ($urandom_range(0, 99) < 10) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        for (int a = 0; a < n_args; a++)
        begin
            sel = $urandom_range(0, 99);
            n_dig = (sel < 20) ? 0 : (sel < 92) ? $urandom_range(1, 3) : $urandom_range(10, 12);
            for (int k = 0; k < n_dig; k++)
            begin
                if ($urandom_range(0, 99) < 4)
                    send_seq_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 127) | 8'h80)
                                                       : 8'($urandom_range(0, 31)));
                send_seq_byte(8'(CH_DIGIT_LO + $urandom_range(0, 9)));
            end
            if (a < n_args - 1 || $urandom_range(0, 1))
                send_seq_byte(CH_SEMI);
        end
        if ($urandom_range(0, 99) < 15)
        begin
            send_seq_byte(8'(CH_INTER_LO + $urandom_range(0, 15)));
            repeat ($urandom_range(0, 2))
                send_seq_byte($urandom_range(0, 1) ? CH_SEMI
                                                   : 8'(CH_DIGIT_LO + $urandom_range(0, 9)));
        end
        sel = $urandom_range(0, 99);
        if (sel < 85)
            send_seq_byte(8'(CH_FINAL_LO + $urandom_range(0, 63)));
        else if (sel < 95)
            send_seq_byte(CH_DOLLAR);
    endtask

    task automatic test_random();
        int start;
        start = n_counted;
        while (n_counted < start + RANDOM_ITEMS)
        begin
            idle_on = !((n_counted - start >= 300) && (n_counted - start < 500));
            send_sequence();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
                out_ch.ready = idle_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.arg_present = out_ch.arg_present;
            got.arg_index = out_ch.arg_index;
            got.arg_value = out_ch.arg_value;
            got.is_final = out_ch.is_final;
            got.final_byte = out_ch.final_byte;
            got.initial_byte = out_ch.initial_byte;
            got.intermediate_byte = out_ch.intermediate_byte;
            got.arg_count = out_ch.arg_count;
            if (expected_results.size() == 0)
            begin
                if (n_errors < 10)
                    $display("unexpected result at cycle %0d: arg %0b/%0d/%0d final %0b/%h",
                             cycles, got.arg_present, got.arg_index, got.arg_value,
                             got.is_final, got.final_byte);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.arg_present !== want.arg_present || got.arg_index !== want.arg_index
                    || got.arg_value !== want.arg_value || got.is_final !== want.is_final
                    || got.final_byte !== want.final_byte
                    || got.initial_byte !== want.initial_byte
                    || got.intermediate_byte !== want.intermediate_byte
                    || got.arg_count !== want.arg_count)
                begin
                    if (n_errors < 10)
                    begin
                        $display("mismatch at cycle %0d: exp arg %0b/%0d/%0d fin %0b/%h ini %h int %h cnt %0d",
                                 cycles, want.arg_present, want.arg_index, want.arg_value,
                                 want.is_final, want.final_byte, want.initial_byte,
                                 want.intermediate_byte, want.arg_count);
                        $display("    got arg %0b/%0d/%0d fin %0b/%h ini %h int %h cnt %0d",
                                 got.arg_present, got.arg_index, got.arg_value,
                                 got.is_final, got.final_byte, got.initial_byte,
                                 got.intermediate_byte, got.arg_count);
                    end
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.byte_in = '0;
        in_ch.begin_req = 1'b0;
        rst_n = 1'b0;
        n_errors = 0;
        n_counted = 0;
        cycles = 0;
        stall_left = 0;
        idle_on = 1'b1;
        seq_begin = 1'b0;
        p_active = 1'b0;
        restart_parse();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic();
        test_dollar_and_intermediate();
        test_saturation_and_limit();
        test_backpressure();
        test_random();

        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
